FILE: sv/i2c_slave_register_file_top_assert.svh
// ---------------------------------------------------------------------------
// I2C slave register file assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef I2C_SLAVE_REGISTER_FILE_TOP_ASSERT_SVH
`define I2C_SLAVE_REGISTER_FILE_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define I2C_SRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2c_srf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2C_SRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2c_srf: next-cycle check failed");

`else

`define I2C_SRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define I2C_SRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/i2c_srf_pkg.sv
// ---------------------------------------------------------------------------
// I2C slave register file package
// Sizes, event codes, register indexes and the output word layout.
// ---------------------------------------------------------------------------
`default_nettype none

package i2c_srf_pkg;

	// Store depth and derived widths
	localparam int DEPTH = 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int MODE_W  = 3;
	localparam int DATA_W  = 8;
	localparam int IDX_W   = 6;
	localparam int FSEL_W  = 2;
	localparam int BUF_W   = 7;
	localparam int PTR_W   = 6;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 32;

	// Event codes
	localparam logic [MODE_W-1:0] MODE_START = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RX    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RD    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STOP  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GCALL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_HWR   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_HRD   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_FLAG  = 3'd7;

	// Flag selects
	localparam logic [FSEL_W-1:0] FSEL_RX = 2'd0;
	localparam logic [FSEL_W-1:0] FSEL_TX = 2'd1;
	localparam logic [FSEL_W-1:0] FSEL_GC = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_BUFSIZE = 1'b0;
	localparam logic [0:0] CFG_ENABLE  = 1'b1;

	localparam logic [BUF_W-1:0]  BUF_RESET     = 7'd64;
	localparam logic [DATA_W-1:0] PAST_END_BYTE = 8'hFF;

	// Result word, lowest field last
	typedef struct packed {
		logic [5:0]        pad;
		logic              wake;
		logic [PTR_W-1:0]  ptr;
		logic              gc;
		logic              tx_done;
		logic              rx_done;
		logic [DATA_W-1:0] host_data;
		logic [DATA_W-1:0] tx_byte;
	} out_word_t;

	// Item held between the access cycle and the output register
	typedef struct packed {
		logic             tx_ram;
		logic             host_ram;
		logic             tx_ff;
		logic             tx_v;
		logic             wake;
		logic             rdv;
		logic             rx_done;
		logic             tx_done;
		logic             gc;
		logic [PTR_W-1:0] ptr;
	} stage_t;

endpackage

`default_nettype wire

FILE: sv/i2c_srf_ram.sv
// ---------------------------------------------------------------------------
// I2C slave register file RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_srf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/i2c_slave_register_file_top.sv
// ---------------------------------------------------------------------------
// I2C slave register file
// Register-pointer buffer behind an I2C slave, driven by bus and host events.
// ---------------------------------------------------------------------------
// Each input word is one event: a bus event (start, received byte, read
// request, stop, general call) or a host access (buffer write, buffer read,
// flag write), selected by s_tuser. Every event yields exactly one result
// word carrying the transmit byte, the host read byte, the three status
// flags, the internal pointer and a wake bit. The block takes one word per
// clock unless stalled: all pointer and flag state updates in the accept
// cycle, the buffer RAM answers in the next cycle, and a result register
// holds the word for the downstream side. The word passes two register
// stages (the RAM stage and the result register); m_tvalid rises once the
// word moves from the RAM stage into the result register. Input is
// stalled only when both the RAM stage and the result register are full
// and m_tready is low. The buffer reads as zero after reset: a
// flip-flop valid bit per entry, cleared by reset, masks entries never
// written, so there is no clearing pass. Configuration (buffer_size at
// index 0, slave_enable at index 1) is written through cfg_we and should
// only change while no event is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_slave_register_file_top (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_wdata,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // data_byte[7:0], host_index[13:8], flag_select[15:14]
	input  wire logic [2:0]  s_tuser,   // mode[2:0]

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // tx_byte[7:0], host_data[15:8], rx_done[16],
	                                    // tx_done[17], general_call_seen[18],
	                                    // pointer_address[24:19], wake[25], zero[31:26]
	output logic [0:0]       m_tuser    // tx_valid[0]
);

`include "i2c_slave_register_file_top_assert.svh"

	localparam int AW = i2c_srf_pkg::AW;
	localparam int PW = i2c_srf_pkg::PW;

	// Configuration registers
	logic [i2c_srf_pkg::BUF_W-1:0] buf_q;
	logic                          en_q;

	// Transfer state
	logic [PW-1:0]          pos_q;
	logic [AW-1:0]          ptr_q;
	logic                   start_q;
	logic                   rxa_q;
	logic                   txa_q;
	logic                   rxd_q;
	logic                   txd_q;
	logic                   gc_q;
	logic [i2c_srf_pkg::DEPTH-1:0] vld_q;

	// Input word fields
	logic [i2c_srf_pkg::MODE_W-1:0] mode;
	logic [i2c_srf_pkg::DATA_W-1:0] data;
	logic [i2c_srf_pkg::IDX_W-1:0]  hidx;
	logic [i2c_srf_pkg::FSEL_W-1:0] fsel;

	assign mode = s_tuser;
	assign data = s_tdata[7:0];
	assign hidx = s_tdata[13:8];
	assign fsel = s_tdata[15:14];

	logic acc;
	assign acc = s_tvalid && s_tready;

	// Active size: smaller of buffer_size and the store depth
	logic [PW-1:0] lim;
	always_comb begin
		if (int'(buf_q) > i2c_srf_pkg::DEPTH) begin
			lim = PW'(i2c_srf_pkg::DEPTH);
		end else begin
			lim = PW'(buf_q);
		end
	end

	logic          pos_in;
	logic          data_in;
	logic          hidx_in;
	logic [PW-1:0] rd_pos;
	logic          rd_in;

	assign pos_in  = int'(pos_q) < int'(lim);
	assign data_in = int'(data) < int'(lim);
	assign hidx_in = int'(hidx) < i2c_srf_pkg::DEPTH;
	// a read after start begins at the internal pointer
	assign rd_pos  = start_q ? PW'(ptr_q) : pos_q;
	assign rd_in   = int'(rd_pos) < int'(lim);

	// Next state and RAM access for the word at the input
	logic [PW-1:0]  n_pos;
	logic [AW-1:0]  n_ptr;
	logic           n_start;
	logic           n_rxa;
	logic           n_txa;
	logic           n_rxd;
	logic           n_txd;
	logic           n_gc;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	i2c_srf_pkg::stage_t n_s1;

	always_comb begin
		n_pos     = pos_q;
		n_ptr     = ptr_q;
		n_start   = start_q;
		n_rxa     = rxa_q;
		n_txa     = txa_q;
		n_rxd     = rxd_q;
		n_txd     = txd_q;
		n_gc      = gc_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		n_s1      = '0;

		case (mode)
			i2c_srf_pkg::MODE_START: begin
				if (en_q) begin
					n_start = 1'b1;
					n_pos   = '0;
				end
			end
			i2c_srf_pkg::MODE_RX: begin
				if (en_q) begin
					if (start_q) begin
						// first byte sets the pointer, out of range falls back to 0
						n_start = 1'b0;
						n_rxa   = 1'b1;
						n_ptr   = data_in ? AW'(data) : '0;
						n_pos   = data_in ? PW'(data) : '0;
					end else if (pos_in) begin
						ram_we    = 1'b1;
						ram_waddr = pos_q[AW-1:0];
						n_pos     = pos_q + PW'(1);
					end
				end
			end
			i2c_srf_pkg::MODE_RD: begin
				if (en_q) begin
					if (start_q) begin
						n_start = 1'b0;
						n_txa   = 1'b1;
					end
					if (rd_in) begin
						ram_re      = 1'b1;
						ram_raddr   = rd_pos[AW-1:0];
						n_s1.tx_ram = 1'b1;
						n_pos       = rd_pos + PW'(1);
					end else begin
						n_s1.tx_ff = 1'b1;
						n_pos      = rd_pos;
					end
					n_s1.tx_v = 1'b1;
				end
			end
			i2c_srf_pkg::MODE_STOP: begin
				if (en_q) begin
					if (rxa_q) begin
						n_rxa = 1'b0;
						n_rxd = 1'b1;
					end
					if (txa_q) begin
						n_txa = 1'b0;
						n_txd = 1'b1;
					end
					n_s1.wake = 1'b1;
				end
			end
			i2c_srf_pkg::MODE_GCALL: begin
				if (en_q) begin
					n_gc      = 1'b1;
					n_s1.wake = 1'b1;
				end
			end
			i2c_srf_pkg::MODE_HWR: begin
				if (hidx_in) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(hidx);
				end
			end
			i2c_srf_pkg::MODE_HRD: begin
				if (hidx_in) begin
					ram_re        = 1'b1;
					ram_raddr     = AW'(hidx);
					n_s1.host_ram = 1'b1;
				end
			end
			i2c_srf_pkg::MODE_FLAG: begin
				case (fsel)
					i2c_srf_pkg::FSEL_RX: n_rxd = data[0];
					i2c_srf_pkg::FSEL_TX: n_txd = data[0];
					i2c_srf_pkg::FSEL_GC: n_gc  = data[0];
					default: ;
				endcase
			end
			default: ;
		endcase

		n_s1.rdv     = vld_q[ram_raddr];
		n_s1.rx_done = n_rxd;
		n_s1.tx_done = n_txd;
		n_s1.gc      = n_gc;
		n_s1.ptr     = i2c_srf_pkg::PTR_W'(n_ptr);
	end

	// Buffer RAM
	logic [i2c_srf_pkg::DATA_W-1:0] ram_rdata;

	i2c_srf_ram #(
		.WIDTH(i2c_srf_pkg::DATA_W),
		.DEPTH(i2c_srf_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (acc && ram_we),
		.waddr(ram_waddr),
		.wdata(data),
		.re   (acc && ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= i2c_srf_pkg::BUF_RESET;
			en_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				i2c_srf_pkg::CFG_BUFSIZE: buf_q <= cfg_wdata;
				i2c_srf_pkg::CFG_ENABLE:  en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Transfer state and entry valid bits advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ptr_q   <= '0;
			start_q <= 1'b0;
			rxa_q   <= 1'b0;
			txa_q   <= 1'b0;
			rxd_q   <= 1'b0;
			txd_q   <= 1'b0;
			gc_q    <= 1'b0;
			vld_q   <= '0;
		end else if (acc) begin
			pos_q   <= n_pos;
			ptr_q   <= n_ptr;
			start_q <= n_start;
			rxa_q   <= n_rxa;
			txa_q   <= n_txa;
			rxd_q   <= n_rxd;
			txd_q   <= n_txd;
			gc_q    <= n_gc;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// RAM stage: word waits here for the read data
	logic                v_s1;
	i2c_srf_pkg::stage_t w_s1;
	logic                adv;
	logic                out_valid_q;

	assign adv      = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			w_s1 <= n_s1;
		end
	end

	// Merge read data; an entry never written reads as zero
	logic [i2c_srf_pkg::DATA_W-1:0] rd_byte;
	i2c_srf_pkg::out_word_t         n_out;

	always_comb begin
		rd_byte = w_s1.rdv ? ram_rdata : '0;
		n_out   = '0;
		if (w_s1.tx_ram) begin
			n_out.tx_byte = rd_byte;
		end else if (w_s1.tx_ff) begin
			n_out.tx_byte = i2c_srf_pkg::PAST_END_BYTE;
		end
		n_out.host_data = w_s1.host_ram ? rd_byte : '0;
		n_out.rx_done   = w_s1.rx_done;
		n_out.tx_done   = w_s1.tx_done;
		n_out.gc        = w_s1.gc;
		n_out.ptr       = w_s1.ptr;
		n_out.wake      = w_s1.wake;
	end

	// Result register
	logic                   out_txv_q;
	i2c_srf_pkg::out_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q     <= n_out;
			out_txv_q <= w_s1.tx_v;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_txv_q;

	// Checks
	`I2C_SRF_ASSERT_NEXT(a_wr_sets_valid, clk, arst_n, acc && ram_we, vld_q[$past(ram_waddr)])
	`I2C_SRF_ASSERT_SAME(a_out_from_stage, clk, arst_n, $rose(out_valid_q), $past(v_s1))
	`I2C_SRF_ASSERT_SAME(a_txv_no_wake, clk, arst_n, out_valid_q, !(out_txv_q && out_q.wake))
	`I2C_SRF_ASSERT_NEXT(a_start_arms, clk, arst_n, acc && en_q && (mode == i2c_srf_pkg::MODE_START), start_q && (pos_q == '0))

endmodule

`default_nettype wire
